>>> src/shb_pkg.sv
// Package for the string hash bucket block.
// Widths, reset constants, controller state and the command/status structs.
// No dependencies.
package shb_pkg;

	localparam int ACC_W  = 64;
	localparam int TS_W   = 32;
	localparam int CHAR_W = 8;
	localparam int CNT_W  = $clog2(ACC_W);

	localparam logic [TS_W-1:0]  MODULUS_RST = TS_W'(1024);
	localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(ACC_W - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} shb_state_t;

	typedef struct packed {
		logic accept_item;
		logic start_div;
		logic step_div;
		logic load_out;
	} shb_cmd_t;

	typedef struct packed {
		logic div_last;
	} shb_sts_t;

endpackage

>>> src/string_hash_bucket.sv
// String hash bucket: while idle, a character item is taken every cycle and, if
// has_char, folded into the 64-bit accumulator in the cycle it transfers. The
// item marked last starts the remainder unit, which retires one dividend bit per
// cycle: bucket is valid, and the next item is taken, once the remainder sits in
// the output register. Reset (arst_n low) clears the accumulator and output
// valid, returns the controller to idle and sets the modulus to 1024.
module string_hash_bucket (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [shb_pkg::TS_W-1:0]    cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [shb_pkg::CHAR_W-1:0] char_value,
	input  logic                        has_char,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [shb_pkg::TS_W-1:0]    bucket
);
	import shb_pkg::*;

	shb_cmd_t cmd;
	shb_sts_t sts;

	assign cfg_ready = 1'b1;

	shb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	shb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_data   (cfg_data),
		.char_value (char_value),
		.has_char   (has_char),
		.last       (last),
		.cmd        (cmd),
		.sts        (sts),
		.bucket     (bucket)
	);

endmodule

>>> src/shb_ctrl.sv
// Controller for the string hash bucket block: state machine and output valid.
// Depends on shb_pkg.
module shb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            last,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  shb_pkg::shb_sts_t sts,
	output shb_pkg::shb_cmd_t cmd
);
	import shb_pkg::*;

	shb_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && last) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd.accept_item = 1'b0;
		cmd.start_div   = 1'b0;
		cmd.step_div    = 1'b0;
		cmd.load_out    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.accept_item = in_valid;
				cmd.start_div   = in_valid && last;
			end
			ST_DIV: begin
				cmd.step_div = 1'b1;
			end
			ST_FIN: begin
				// wait for the output register to drain
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> src/shb_dp.sv
// Datapath for the string hash bucket block: accumulator, table size register,
// radix-2 restoring remainder unit and output register. Depends on shb_pkg.
module shb_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [shb_pkg::TS_W-1:0]    cfg_data,
	input  logic signed [shb_pkg::CHAR_W-1:0] char_value,
	input  logic                        has_char,
	input  logic                        last,
	input  shb_pkg::shb_cmd_t           cmd,
	output shb_pkg::shb_sts_t           sts,
	output logic [shb_pkg::TS_W-1:0]    bucket
);
	import shb_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_upd;
	logic [ACC_W-1:0] char_ext;
	logic [TS_W-1:0]  modulus_q;
	logic [ACC_W-1:0] dvd_q;
	logic [TS_W-1:0]  rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TS_W:0]    rem_sh;
	logic [TS_W:0]    rem_diff;
	logic [TS_W-1:0]  bucket_q;

	assign char_ext = {{(ACC_W-CHAR_W){char_value[CHAR_W-1]}}, char_value};
	// times 31 is shift by five minus one copy
	assign acc_upd  = has_char ? ((acc_q << 5) - acc_q + char_ext) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.accept_item) begin
			acc_q <= last ? '0 : acc_upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
		end else if (cfg_we) begin
			// saturate a zero modulus to one
			modulus_q <= (cfg_data == '0) ? TS_W'(1) : cfg_data;
		end
	end

	assign rem_sh   = {rem_q, dvd_q[ACC_W-1]};
	assign rem_diff = rem_sh - {1'b0, modulus_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_div) begin
			cnt_q <= '0;
		end else if (cmd.step_div) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			dvd_q <= acc_upd;
			rem_q <= '0;
		end else if (cmd.step_div) begin
			dvd_q <= dvd_q << 1;
			rem_q <= (rem_sh >= {1'b0, modulus_q}) ? rem_diff[TS_W-1:0]
				: rem_sh[TS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			bucket_q <= rem_q;
		end
	end

	assign sts.div_last = (cnt_q == CNT_LAST);
	assign bucket       = bucket_q;

endmodule

>>> src/shb_checker.sv
// Port-level checks for the string hash bucket block, bound to the top level.
// Depends on shb_pkg and string_hash_bucket.
module shb_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     last,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [shb_pkg::TS_W-1:0] bucket
);
	import shb_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bucket))
		else $error("bucket changed while stalled");

	// a word end makes the block busy on the next cycle
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("input taken during remainder computation");

	// a new result only appears after a busy cycle
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word end");

endmodule

bind string_hash_bucket shb_checker u_shb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.bucket    (bucket)
);
